### rtl/ftma_pkg.sv
`default_nettype none

package ftma_pkg;

  localparam int TS_W      = 63;
  localparam int TGT_W     = 32;
  localparam int SCALE_W   = 27;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W    = 16;
  localparam int HALF_W    = 32;
  localparam int LO_PROD_W = HALF_W + SCALE_W;
  localparam int HI_PROD_W = TS_W - HALF_W + SCALE_W;
  localparam int SUM_W     = 64;

  // depth of the moving average window, a power of two
  localparam int RING_SIZE  = 16;
  localparam int RING_IDX_W = $clog2(RING_SIZE);
  localparam int AVG_SHIFT  = $clog2(RING_SIZE);

  localparam logic CMD_FRAME   = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAME_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UI_SCALE     = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_ONE = 27'd65536;
  localparam logic [TS_W-1:0]    TS_MAX    = {TS_W{1'b1}};

  typedef logic [TS_W-1:0]      ts_t;
  typedef logic [LO_PROD_W-1:0] lo_prod_t;
  typedef logic [HI_PROD_W-1:0] hi_prod_t;

  // floor(delta * scale / 2^16) from the two partial products, saturated
  function automatic ts_t scale_sat(input lo_prod_t plo, input hi_prod_t phi);
    logic [SUM_W-1:0] sum;
    logic             ovf;
    sum = {1'b0, phi[TS_W-FRAC_W-1:0], {FRAC_W{1'b0}}}
        + {{(SUM_W-LO_PROD_W+FRAC_W){1'b0}}, plo[LO_PROD_W-1:FRAC_W]};
    ovf = (phi[HI_PROD_W-1:TS_W-FRAC_W] != '0) || sum[SUM_W-1];
    return ovf ? TS_MAX : sum[TS_W-1:0];
  endfunction

  function automatic ts_t sat_add(input ts_t a, input ts_t b);
    logic [TS_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TS_W] ? TS_MAX : sum[TS_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/frame_timer_with_moving_average.sv
`default_nettype none

// channel  | handshake                       | payload
// ---------+---------------------------------+-----------------------------------------
// item     | item_valid / item_stall         | command, timestamp
// result   | result_valid / result_stall     | wait_ticks .. avg_frame_time (8 fields)
// config   | cfg_we                          | cfg_index, cfg_data
//
// one item per cycle when nothing stalls downstream
// a result passes through the six-register pipeline: input, time base, delta, multipliers,
// scaling, result register
// rst clears every stage valid, the time state, the accumulators and the 16-entry ring
// result_stall holds the result register; each stage takes a new item whenever it is
// empty or its content moves on, so bubbles close up under a stall

module frame_timer_with_moving_average (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            item_valid,
  output logic                           item_stall,
  input  wire                            command,
  input  wire  [ftma_pkg::TS_W-1:0]      timestamp,
  output logic                           result_valid,
  input  wire                            result_stall,
  output logic [ftma_pkg::TGT_W-1:0]     wait_ticks,
  output logic [ftma_pkg::TS_W-1:0]      relative_time,
  output logic [ftma_pkg::TS_W-1:0]      frame_delta,
  output logic [ftma_pkg::TS_W-1:0]      game_delta,
  output logic [ftma_pkg::TS_W-1:0]      ui_delta,
  output logic [ftma_pkg::TS_W-1:0]      game_elapsed,
  output logic [ftma_pkg::TS_W-1:0]      ui_elapsed,
  output logic [ftma_pkg::TS_W-1:0]      avg_frame_time,
  input  wire                            cfg_we,
  input  wire  [ftma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [ftma_pkg::CFG_W-1:0]     cfg_data
);
  import ftma_pkg::*;

  logic [TGT_W-1:0]   frame_target;
  logic [SCALE_W-1:0] game_scale;
  logic [SCALE_W-1:0] ui_scale;

  ts_t                 base_time;
  ts_t                 last_frame_start;
  ts_t                 game_accum;
  ts_t                 ui_accum;
  ts_t                 ring [RING_SIZE];
  logic [RING_IDX_W-1:0] ring_pos;
  logic [SUM_W-1:0]    ring_sum;

  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  logic s1_cmd;
  ts_t  s1_ts;
  logic s2_cmd;
  ts_t  s2_rel;
  logic s3_cmd;
  ts_t  s3_rel, s3_delta;
  logic s4_cmd;
  ts_t  s4_rel, s4_delta, s4_avg;
  logic [TGT_W-1:0] s4_wait;
  lo_prod_t s4_glo, s4_ulo;
  hi_prod_t s4_ghi, s4_uhi;
  logic s5_cmd;
  ts_t  s5_rel, s5_delta, s5_avg, s5_gd, s5_ud;
  logic [TGT_W-1:0] s5_wait;

  logic [TGT_W-1:0] wait_next;
  logic [SUM_W-1:0] ring_sum_next;
  ts_t              game_accum_next, ui_accum_next;

  assign rdy6 = !result_valid || !result_stall;
  assign rdy5 = !s5_valid || rdy6;
  assign rdy4 = !s4_valid || rdy5;
  assign rdy3 = !s3_valid || rdy4;
  assign rdy2 = !s2_valid || rdy3;
  assign rdy1 = !s1_valid || rdy2;
  assign item_stall = !rdy1;

  always_comb begin
    wait_next = '0;
    if (frame_target != '0 && s3_delta[TS_W-1:TGT_W] == '0
        && s3_delta[TGT_W-1:0] < frame_target) begin
      wait_next = frame_target - s3_delta[TGT_W-1:0];
    end
    ring_sum_next = ring_sum - {1'b0, ring[ring_pos]} + {1'b0, s3_delta};
    game_accum_next = sat_add(game_accum, s5_gd);
    ui_accum_next   = sat_add(ui_accum, s5_ud);
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_target <= '0;
      game_scale   <= SCALE_ONE;
      ui_scale     <= SCALE_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_TARGET: frame_target <= cfg_data[TGT_W-1:0];
        REG_GAME_SCALE:   game_scale   <= cfg_data[SCALE_W-1:0];
        REG_UI_SCALE:     ui_scale     <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy1) s1_valid     <= item_valid;
      if (rdy2) s2_valid     <= s1_valid;
      if (rdy3) s3_valid     <= s2_valid;
      if (rdy4) s4_valid     <= s3_valid;
      if (rdy5) s5_valid     <= s4_valid;
      if (rdy6) result_valid <= s5_valid;
    end
  end

  // timing state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_time        <= '0;
      last_frame_start <= '0;
      game_accum       <= '0;
      ui_accum         <= '0;
      ring_pos         <= '0;
      ring_sum         <= '0;
      for (int i = 0; i < RING_SIZE; i++) begin
        ring[i] <= '0;
      end
    end else begin
      if (s1_valid && rdy2 && s1_cmd == CMD_RESTART) begin
        base_time <= s1_ts;
      end
      if (s2_valid && rdy3) begin
        last_frame_start <= (s2_cmd == CMD_RESTART) ? '0 : s2_rel;
      end
      if (s3_valid && rdy4 && s3_cmd == CMD_FRAME) begin
        ring[ring_pos] <= s3_delta;
        ring_sum       <= ring_sum_next;
        ring_pos       <= (ring_pos == RING_IDX_W'(RING_SIZE - 1)) ? '0 : ring_pos + 1'b1;
      end
      if (s5_valid && rdy6) begin
        game_accum <= (s5_cmd == CMD_RESTART) ? '0 : game_accum_next;
        ui_accum   <= (s5_cmd == CMD_RESTART) ? '0 : ui_accum_next;
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (item_valid && rdy1) begin
      s1_cmd <= command;
      s1_ts  <= timestamp;
    end
    if (s1_valid && rdy2) begin
      s2_cmd <= s1_cmd;
      s2_rel <= s1_ts - base_time;
    end
    if (s2_valid && rdy3) begin
      s3_cmd   <= s2_cmd;
      s3_rel   <= s2_rel;
      s3_delta <= s2_rel - last_frame_start;
    end
    if (s3_valid && rdy4) begin
      s4_cmd   <= s3_cmd;
      s4_rel   <= s3_rel;
      s4_delta <= s3_delta;
      s4_wait  <= wait_next;
      s4_avg   <= (s3_cmd == CMD_RESTART) ? TS_W'(ring_sum >> AVG_SHIFT)
                                          : TS_W'(ring_sum_next >> AVG_SHIFT);
      s4_glo <= LO_PROD_W'(s3_delta[HALF_W-1:0]) * LO_PROD_W'(game_scale);
      s4_ulo <= LO_PROD_W'(s3_delta[HALF_W-1:0]) * LO_PROD_W'(ui_scale);
      s4_ghi <= HI_PROD_W'(s3_delta[TS_W-1:HALF_W]) * HI_PROD_W'(game_scale);
      s4_uhi <= HI_PROD_W'(s3_delta[TS_W-1:HALF_W]) * HI_PROD_W'(ui_scale);
    end
    if (s4_valid && rdy5) begin
      s5_cmd   <= s4_cmd;
      s5_rel   <= s4_rel;
      s5_delta <= s4_delta;
      s5_wait  <= s4_wait;
      s5_avg   <= s4_avg;
      s5_gd    <= scale_sat(s4_glo, s4_ghi);
      s5_ud    <= scale_sat(s4_ulo, s4_uhi);
    end
    if (s5_valid && rdy6) begin
      if (s5_cmd == CMD_RESTART) begin
        wait_ticks     <= '0;
        relative_time  <= '0;
        frame_delta    <= '0;
        game_delta     <= '0;
        ui_delta       <= '0;
        game_elapsed   <= '0;
        ui_elapsed     <= '0;
        avg_frame_time <= '0;
      end else begin
        wait_ticks     <= s5_wait;
        relative_time  <= s5_rel;
        frame_delta    <= s5_delta;
        game_delta     <= s5_gd;
        ui_delta       <= s5_ud;
        game_elapsed   <= game_accum_next;
        ui_elapsed     <= ui_accum_next;
        avg_frame_time <= s5_avg;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ftma_checker.sv
`default_nettype none

module ftma_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        result_valid,
  input wire                        result_stall,
  input wire [ftma_pkg::TGT_W-1:0]  wait_ticks,
  input wire [ftma_pkg::TS_W-1:0]   frame_delta,
  input wire [ftma_pkg::TS_W-1:0]   game_delta,
  input wire [ftma_pkg::TS_W-1:0]   ui_delta,
  input wire [ftma_pkg::TS_W-1:0]   game_elapsed,
  input wire [ftma_pkg::TS_W-1:0]   ui_elapsed
);
  import ftma_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(frame_delta)
      && $stable(game_elapsed) && $stable(wait_ticks))
    else $error("stalled result changed");

  a_zero_delta: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_delta == '0 |-> game_delta == '0 && ui_delta == '0)
    else $error("zero frame delta scaled to nonzero");

  a_elapsed_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> game_elapsed >= game_delta && ui_elapsed >= ui_delta)
    else $error("elapsed time below this frame's delta");

endmodule

bind frame_timer_with_moving_average ftma_checker u_ftma_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .wait_ticks   (wait_ticks),
  .frame_delta  (frame_delta),
  .game_delta   (game_delta),
  .ui_delta     (ui_delta),
  .game_elapsed (game_elapsed),
  .ui_elapsed   (ui_elapsed)
);

`default_nettype wire

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ftma_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int PIPE_DEPTH  = 6;
  localparam int HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int PHASE_ITEMS = 110;
  localparam int PHASES      = 5;
  localparam int PRINT_LIMIT = 40;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  typedef struct {
    logic [TGT_W-1:0] wait_ticks;
    ts_t              relative_time;
    ts_t              frame_delta;
    ts_t              game_delta;
    ts_t              ui_delta;
    ts_t              game_elapsed;
    ts_t              ui_elapsed;
    ts_t              avg_frame_time;
  } frame_result_t;

  class frame_timer_scoreboard;
    logic [TGT_W-1:0]      target;
    logic [SCALE_W-1:0]    game_scale;
    logic [SCALE_W-1:0]    ui_scale;
    ts_t                   base;
    ts_t                   last_start;
    ts_t                   game_total;
    ts_t                   ui_total;
    ts_t                   window [RING_SIZE];
    logic [RING_IDX_W-1:0] slot;
    logic [SUM_W-1:0]      window_sum;
    frame_result_t         expected_q [$];
    int                    errors;
    int                    accepted;
    int                    checked;
    int                    restarts;
    int                    owed;
    int                    saturated;

    function new();
      target     = '0;
      game_scale = SCALE_ONE;
      ui_scale   = SCALE_ONE;
      base       = '0;
      last_start = '0;
      game_total = '0;
      ui_total   = '0;
      foreach (window[i]) window[i] = '0;
      slot       = '0;
      window_sum = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_FRAME_TARGET: target = data[TGT_W-1:0];
        REG_GAME_SCALE:   game_scale = data[SCALE_W-1:0];
        REG_UI_SCALE:     ui_scale = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // floor(delta * scale / 2^16) clipped to the 63-bit maximum
    function ts_t scaled(ts_t d, logic [SCALE_W-1:0] s);
      logic [TS_W+SCALE_W-1:0] prod;
      prod = d;
      prod = prod * s;
      if (prod[TS_W+SCALE_W-1:TS_W+FRAC_W] != '0) return TS_MAX;
      return prod[TS_W+FRAC_W-1:FRAC_W];
    endfunction

    function ts_t add_capped(ts_t a, ts_t b);
      logic [TS_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TS_W] ? TS_MAX : s[TS_W-1:0];
    endfunction

    function void note_item(logic cmd, ts_t ts);
      frame_result_t r;
      ts_t           rel;
      ts_t           delta;
      logic [SUM_W-1:0] avg;
      accepted++;
      r = '{default: '0};
      if (cmd == CMD_RESTART) begin
        base       = ts;
        last_start = '0;
        game_total = '0;
        ui_total   = '0;
        restarts++;
      end else begin
        rel   = ts - base;
        delta = rel - last_start;
        if (target != '0 && delta < target) begin
          r.wait_ticks = target - delta[TGT_W-1:0];
          owed++;
        end
        r.relative_time = rel;
        r.frame_delta   = delta;
        r.game_delta    = scaled(delta, game_scale);
        r.ui_delta      = scaled(delta, ui_scale);
        if (r.game_delta == TS_MAX || r.ui_delta == TS_MAX) saturated++;
        game_total = add_capped(game_total, r.game_delta);
        ui_total   = add_capped(ui_total, r.ui_delta);
        r.game_elapsed = game_total;
        r.ui_elapsed   = ui_total;
        // running window sum wraps at 64 bits
        window_sum   = window_sum - window[slot] + delta;
        window[slot] = delta;
        slot++;
        avg = window_sum >> AVG_SHIFT;
        r.avg_frame_time = avg[TS_W-1:0];
        last_start = rel;
      end
      expected_q.push_back(r);
    endfunction

    function void compare(string name, ts_t want, ts_t got);
      if (want !== got) begin
        errors++;
        if (errors <= PRINT_LIMIT)
          $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= PRINT_LIMIT)
          $display("%0t: result transfer with nothing expected", $time);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare("wait_ticks", want.wait_ticks, got.wait_ticks);
      compare("relative_time", want.relative_time, got.relative_time);
      compare("frame_delta", want.frame_delta, got.frame_delta);
      compare("game_delta", want.game_delta, got.game_delta);
      compare("ui_delta", want.ui_delta, got.ui_delta);
      compare("game_elapsed", want.game_elapsed, got.game_elapsed);
      compare("ui_elapsed", want.ui_elapsed, got.ui_elapsed);
      compare("avg_frame_time", want.avg_frame_time, got.avg_frame_time);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag_leftover();
      if (expected_q.size() != 0) begin
        errors += expected_q.size();
        $display("%0t: %0d results never arrived", $time, expected_q.size());
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  logic                 command      = CMD_FRAME;
  ts_t                  timestamp    = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [TGT_W-1:0]     wait_ticks;
  ts_t                  relative_time;
  ts_t                  frame_delta;
  ts_t                  game_delta;
  ts_t                  ui_delta;
  ts_t                  game_elapsed;
  ts_t                  ui_elapsed;
  ts_t                  avg_frame_time;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_FRAME_TARGET;
  logic [CFG_W-1:0]     cfg_data     = '0;

  logic                  hold_req = 1'b0;
  int                    cycles   = 0;
  frame_result_t         seen;
  frame_timer_scoreboard sb;

  frame_timer_with_moving_average dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .command        (command),
    .timestamp      (timestamp),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .wait_ticks     (wait_ticks),
    .relative_time  (relative_time),
    .frame_delta    (frame_delta),
    .game_delta     (game_delta),
    .ui_delta       (ui_delta),
    .game_elapsed   (game_elapsed),
    .ui_elapsed     (ui_elapsed),
    .avg_frame_time (avg_frame_time),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      seen.wait_ticks     = wait_ticks;
      seen.relative_time  = relative_time;
      seen.frame_delta    = frame_delta;
      seen.game_delta     = game_delta;
      seen.ui_delta       = ui_delta;
      seen.game_elapsed   = game_elapsed;
      seen.ui_elapsed     = ui_elapsed;
      seen.avg_frame_time = avg_frame_time;
      sb.check_result(seen);
    end
  end

  // result side stalls in segments; a requested hold-off lets the pipeline fill
  initial begin : receiver
    stall_mode_t mode;
    int          seg_len;
    forever begin
      mode    = stall_mode_t'($urandom_range(0, 3));
      seg_len = $urandom_range(10, 150);
      for (int n = 0; n < seg_len; n++) begin
        @(negedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          result_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (mode)
          STALL_NONE:     result_stall <= 1'b0;
          STALL_LIGHT:    result_stall <= ($urandom_range(0, 99) < 30);
          STALL_PERIODIC: result_stall <= (n % 5 >= 3);
          default:        result_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  function automatic ts_t rand_ts();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TS_W-1:0];
  endfunction

  task automatic send_item(input logic cmd, input ts_t ts);
    item_valid <= 1'b1;
    command    <= cmd;
    timestamp  <= ts;
    do @(posedge clk); while (item_stall);
    sb.note_item(cmd, ts);
    @(negedge clk);
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] tgt, input logic [CFG_W-1:0] game,
                              input logic [CFG_W-1:0] ui);
    write_reg(REG_FRAME_TARGET, tgt);
    write_reg(REG_GAME_SCALE, game);
    write_reg(REG_UI_SCALE, ui);
    write_reg(REG_UNUSED, $urandom);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_directed();
    // default registers: unlimited rate, unit scales
    send_item(CMD_FRAME, '0);
    send_item(CMD_FRAME, 63'd1000);
    send_item(CMD_FRAME, TS_MAX);
    send_item(CMD_RESTART, TS_MAX);
    // timestamps before the base, then before the last frame start
    send_item(CMD_FRAME, 63'd5);
    send_item(CMD_RESTART, 63'd1000);
    send_item(CMD_FRAME, 63'd10);
    send_item(CMD_FRAME, 63'd5);
    item_valid <= 1'b0;
    settle();
    // oversized game scale keeps only its low bits, ui scale zero
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_item(CMD_RESTART, '0);
    send_item(CMD_FRAME, TS_MAX);
    send_item(CMD_FRAME, TS_MAX);
    send_item(CMD_FRAME, 63'd3);
    // huge deltas overflow the window sum
    for (int k = 1; k <= RING_SIZE - 3; k++) send_item(CMD_FRAME, TS_MAX - k);
    item_valid <= 1'b0;
  endtask

  task automatic configure_phase(input int phase);
    case (phase)
      0: program_regs(32'd0, CFG_W'(SCALE_ONE), CFG_W'(SCALE_ONE));
      1: program_regs($urandom_range(1, 5000), $urandom_range(0, 131072000),
                      $urandom_range(0, 131072000));
      2: program_regs(32'hFFFF_FFFF, 32'd0, 32'h07FF_FFFF);
      3: program_regs($urandom, $urandom, $urandom);
      default: program_regs(32'd1, $urandom_range(0, 262144),
                            $urandom_range(61440, 69632));
    endcase
  endtask

  task automatic run_random_phase(input int count);
    ts_t  now;
    logic cmd;
    int   pick;
    int   burst;
    int   gap;
    now      = rand_ts() >> $urandom_range(1, 62);
    hold_req = 1'b1;
    burst    = $urandom_range(1, 24);
    send_item(CMD_RESTART, now);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      cmd  = CMD_FRAME;
      if (pick < 5) cmd = CMD_RESTART;
      else if (pick < 75) now += $urandom_range(0, 6000);
      else if (pick < 83) now += $urandom;
      else if (pick < 86) now += rand_ts();
      else if (pick < 90) now -= $urandom_range(1, 2000);
      else begin
        cmd = 1'($urandom_range(0, 1));
        now = rand_ts();
      end
      send_item(cmd, now);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          item_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    item_valid <= 1'b0;
  endtask

  initial begin
    int waited;
    sb = new();
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      settle();
      configure_phase(p);
      run_random_phase(PHASE_ITEMS);
    end
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (PIPE_DEPTH * 4) @(negedge clk);
    sb.flag_leftover();
    $display("run covered %0d item transfers and %0d checked results, %0d of them restarts",
             sb.accepted, sb.checked, sb.restarts);
    $display("%0d frames owed a wait, %0d frames hit a saturated scaled delta",
             sb.owed, sb.saturated);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
